@@ rtl/assert_macros.svh @@
// assertion helpers included by siphash_2_4_engine_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising edge of clk, switched off while reset is low
`define SH24_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form of the above
`define SH24_ASSERT_IMP(label, cond, prop, msg) \
	`SH24_ASSERT(label, (cond) |-> (prop), msg)

`endif

@@ rtl/sh24_pkg.sv @@
`default_nettype none
package sh24_pkg;

	typedef logic [3:0][63:0] chain_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ABS,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1
	} reg_idx_t;

	localparam logic [63:0] IV0 = 64'h736f6d6570736575;
	localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
	localparam logic [63:0] IV2 = 64'h6c7967656e657261;
	localparam logic [63:0] IV3 = 64'h7465646279746573;
	localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

	localparam logic [1:0] ABS_LAST = 2'd1;
	localparam logic [1:0] FIN_LAST = 2'd3;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned n);
		rotl64 = (x << n) | (x >> (64 - n));
	endfunction

endpackage
`default_nettype wire

@@ rtl/siphash_2_4_engine_top.sv @@
// channel | direction | handshake              | payload
// message | in        | in_valid / in_ready    | message_word, valid_bytes, last_word
// tag     | out       | out_valid / out_ready  | hash_tag
// config  | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one sipround per cycle in a single shared round unit, unless the final round holds;
// words are compressed; a last word is then finalised, a full one after a length-only word
// arst_n clears the key registers to zero and closes any open message
// the tag sits in an output register; a new word is taken while it waits, and
// the last finalisation round holds only if a previous tag is still untaken
// config is always ready; key changes are picked up when the next message opens
`default_nettype none
`include "assert_macros.svh"
module siphash_2_4_engine_top
	import sh24_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] message_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic        last_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      hash_tag,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	state_t      state_q, state_d;
	logic [1:0]  cnt_q;
	logic        open_q, tail_q, fin_q, out_valid_q;
	logic [63:0] key_low_q, key_high_q;
	chain_t      v_q, base_v, rnd_v;
	logic [63:0] m_q, t_q, tag_q;
	logic [7:0]  len_q, len_base, len_add, len_new;
	logic        full, plain, fin_stall;
	logic [63:0] masked, acc_m;

	sh24_round u_round (
		.v_in  (v_q),
		.v_out (rnd_v)
	);

	// chain, length and padded message value seen by an arriving word
	always_comb begin
		if (open_q) begin
			base_v   = v_q;
			len_base = len_q;
		end else begin
			base_v[0] = key_low_q ^ IV0;
			base_v[1] = key_high_q ^ IV1;
			base_v[2] = key_low_q ^ IV2;
			base_v[3] = key_high_q ^ IV3;
			len_base  = 8'd0;
		end
		full    = valid_bytes[3];
		plain   = !last_word || full;
		len_add = plain ? 8'd8 : {5'd0, valid_bytes[2:0]};
		len_new = len_base + len_add;
		for (int i = 0; i < 8; i++) begin
			masked[i*8 +: 8] = (3'(i) < valid_bytes[2:0]) ? message_word[i*8 +: 8] : 8'h00;
		end
		acc_m = plain ? message_word : (masked | {len_new, 56'd0});
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_ABS;
			end
			S_ABS: begin
				if (cnt_q == ABS_LAST && !tail_q) state_d = fin_q ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				if (cnt_q == FIN_LAST && !fin_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		fin_stall = (state_q == S_FIN) && (cnt_q == FIN_LAST) && out_valid_q && !out_ready;
		out_valid = out_valid_q;
		hash_tag  = tag_q;
		cfg_ready = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			open_q      <= 1'b0;
			tail_q      <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			key_low_q   <= '0;
			key_high_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				if (cfg_index == REG_KEY_LOW)  key_low_q  <= cfg_data;
				if (cfg_index == REG_KEY_HIGH) key_high_q <= cfg_data;
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						v_q[0] <= base_v[0];
						v_q[1] <= base_v[1];
						v_q[2] <= base_v[2];
						v_q[3] <= base_v[3] ^ acc_m;
						m_q    <= acc_m;
						t_q    <= {len_new, 56'd0};
						tail_q <= last_word && full;
						fin_q  <= last_word;
						len_q  <= len_new;
						open_q <= !last_word;
						cnt_q  <= '0;
					end
				end
				S_ABS: begin
					v_q   <= rnd_v;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == ABS_LAST) begin
						cnt_q    <= '0;
						v_q[0]   <= rnd_v[0] ^ m_q;
						// full last word: length-only tail goes straight in
						if (tail_q) begin
							m_q    <= t_q;
							v_q[3] <= rnd_v[3] ^ t_q;
							tail_q <= 1'b0;
						end else if (fin_q) begin
							v_q[2] <= rnd_v[2] ^ FIN_XOR;
						end
					end
				end
				S_FIN: begin
					if (!fin_stall) begin
						v_q   <= rnd_v;
						cnt_q <= cnt_q + 2'd1;
						if (cnt_q == FIN_LAST) begin
							tag_q       <= rnd_v[0] ^ rnd_v[1] ^ rnd_v[2] ^ rnd_v[3];
							out_valid_q <= 1'b1;
							fin_q       <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	`SH24_ASSERT(a_busy_after_take, (in_valid && in_ready) |=> !in_ready, "ready after transfer")
	`SH24_ASSERT(a_tag_from_fin, $rose(out_valid) |-> $past(state_q == S_FIN), "tag without finalisation")
	`SH24_ASSERT_IMP(a_fin_no_tail, state_q == S_FIN, !tail_q && fin_q, "finalising with tail pending")
	`SH24_ASSERT_IMP(a_abs_count, state_q == S_ABS, !cnt_q[1], "absorb round count overrun")

endmodule
`default_nettype wire

@@ rtl/sh24_round.sv @@
`default_nettype none
module sh24_round
	import sh24_pkg::*;
(
	input  wire chain_t v_in,
	output chain_t      v_out
);

	logic [63:0] a0, a1, a2, a3;
	logic [63:0] b0, b1, b2, b3;

	always_comb begin
		a0 = v_in[0] + v_in[1];
		a1 = rotl64(v_in[1], 13) ^ a0;
		a0 = rotl64(a0, 32);
		a2 = v_in[2] + v_in[3];
		a3 = rotl64(v_in[3], 16) ^ a2;
		b0 = a0 + a3;
		b3 = rotl64(a3, 21) ^ b0;
		b2 = a2 + a1;
		b1 = rotl64(a1, 17) ^ b2;
		b2 = rotl64(b2, 32);
		v_out[0] = b0;
		v_out[1] = b1;
		v_out[2] = b2;
		v_out[3] = b3;
	end

endmodule
`default_nettype wire
